/* hw/rtl/irpwd_pkg.sv */
// Shared types and constants for the IR pulse-width frame decoder.
// Used by the config registers, the frame FSM and the top level.
// No dependencies.
package irpwd_pkg;

  // Register indexes on the config port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_CODE   = 3'd6;

  // Reset values of the config registers
  localparam logic [7:0] RST_START_MIN = 8'd140;
  localparam logic [7:0] RST_START_MAX = 8'd175;
  localparam logic [7:0] RST_ZERO_MIN  = 8'd39;
  localparam logic [7:0] RST_ZERO_MAX  = 8'd53;
  localparam logic [7:0] RST_ONE_MIN   = 8'd16;
  localparam logic [7:0] RST_ONE_MAX   = 8'd30;
  localparam logic [7:0] RST_ID_CODE   = 8'h0A;

  typedef struct packed {
    logic [7:0] start_min;
    logic [7:0] start_max;
    logic [7:0] zero_min;
    logic [7:0] zero_max;
    logic [7:0] one_min;
    logic [7:0] one_max;
    logic [7:0] id_code;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_BITS  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD_CODE = 2'd2,
    ST_BAD_SUM  = 2'd3
  } status_t;

  // One result word
  typedef struct packed {
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic       last_byte;
    status_t    frame_status;
  } result_t;

  // Inclusive window test
  function automatic logic in_window(input logic [7:0] w, input logic [7:0] lo,
                                     input logic [7:0] hi);
    return (w >= lo) && (w <= hi);
  endfunction

endpackage

/* hw/rtl/irpwd_cfg_regs.sv */
// Configuration register bank of the IR pulse-width frame decoder.
// Depends on irpwd_pkg for the register indexes, reset values and cfg_t.
module irpwd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [irpwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output irpwd_pkg::cfg_t               cfg
);
  import irpwd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Index decode; unused index leaves the bank untouched
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MIN: cfg_nxt.start_min = cfg_data;
        CFG_START_MAX: cfg_nxt.start_max = cfg_data;
        CFG_ZERO_MIN:  cfg_nxt.zero_min  = cfg_data;
        CFG_ZERO_MAX:  cfg_nxt.zero_max  = cfg_data;
        CFG_ONE_MIN:   cfg_nxt.one_min   = cfg_data;
        CFG_ONE_MAX:   cfg_nxt.one_max   = cfg_data;
        CFG_ID_CODE:   cfg_nxt.id_code   = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min <= RST_START_MIN;
      cfg_r.start_max <= RST_START_MAX;
      cfg_r.zero_min  <= RST_ZERO_MIN;
      cfg_r.zero_max  <= RST_ZERO_MAX;
      cfg_r.one_min   <= RST_ONE_MIN;
      cfg_r.one_max   <= RST_ONE_MAX;
      cfg_r.id_code   <= RST_ID_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/irpwd_frame_fsm.sv */
// Frame state machine: classifies one pulse width per step, assembles bytes
// LSB first and judges user code and checksum. Depends on irpwd_pkg.
module irpwd_frame_fsm #(
  parameter int FRAME_BYTES = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           pulse_width,
  input  irpwd_pkg::cfg_t      cfg,
  output logic                 res_vld,
  output irpwd_pkg::result_t   res
);
  import irpwd_pkg::*;

  localparam logic [4:0] FRAME_BYTES_C = 5'(FRAME_BYTES);

  phase_t     phase_r, phase_nxt;
  logic [2:0] bit_count_r, bit_count_nxt;
  logic [7:0] byte_shift_r, byte_shift_nxt;
  logic [3:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] run_sum_r, run_sum_nxt;
  logic       code_ok_r, code_ok_nxt;

  logic       is_zero, is_one, is_start;
  logic [7:0] byte_full;
  logic       last;
  logic       code_ok_now;

  // Pulse classification and byte assembly
  assign is_start    = in_window(pulse_width, cfg.start_min, cfg.start_max);
  assign is_zero     = in_window(pulse_width, cfg.zero_min, cfg.zero_max);
  assign is_one      = !is_zero && in_window(pulse_width, cfg.one_min, cfg.one_max);
  assign byte_full   = byte_shift_r | (8'(is_one) << bit_count_r);
  assign last        = ({1'b0, byte_idx_r} + 5'd1) >= FRAME_BYTES_C;
  assign code_ok_now = (byte_idx_r == 4'd0) ? (byte_full == cfg.id_code) : code_ok_r;

  // Next state and result
  always_comb begin
    phase_nxt          = phase_r;
    bit_count_nxt      = bit_count_r;
    byte_shift_nxt     = byte_shift_r;
    byte_idx_nxt       = byte_idx_r;
    run_sum_nxt        = run_sum_r;
    code_ok_nxt        = code_ok_r;
    res_vld            = 1'b0;
    res.byte_value     = byte_full;
    res.byte_index     = byte_idx_r;
    res.last_byte      = last;
    res.frame_status   = ST_PROGRESS;
    if (last) begin
      if (!code_ok_now)             res.frame_status = ST_BAD_CODE;
      else if (run_sum_r != byte_full) res.frame_status = ST_BAD_SUM;
      else                          res.frame_status = ST_GOOD;
    end
    if (step) begin
      unique case (phase_r)
        PH_START: begin
          bit_count_nxt  = '0;
          byte_shift_nxt = '0;
          byte_idx_nxt   = '0;
          run_sum_nxt    = '0;
          code_ok_nxt    = 1'b0;
          phase_nxt      = is_start ? PH_BITS : PH_IDLE;
        end
        PH_BITS: begin
          if (!is_zero && !is_one) begin
            // abort: drop the partial frame
            phase_nxt      = PH_IDLE;
            bit_count_nxt  = '0;
            byte_shift_nxt = '0;
            byte_idx_nxt   = '0;
            run_sum_nxt    = '0;
            code_ok_nxt    = 1'b0;
          end else if (bit_count_r != 3'd7) begin
            byte_shift_nxt = byte_full;
            bit_count_nxt  = bit_count_r + 3'd1;
          end else begin
            res_vld = 1'b1;
            if (last) begin
              phase_nxt      = PH_IDLE;
              bit_count_nxt  = '0;
              byte_shift_nxt = '0;
              byte_idx_nxt   = '0;
              run_sum_nxt    = '0;
              code_ok_nxt    = 1'b0;
            end else begin
              code_ok_nxt    = code_ok_now;
              run_sum_nxt    = run_sum_r + byte_full;
              byte_idx_nxt   = byte_idx_r + 4'd1;
              bit_count_nxt  = '0;
              byte_shift_nxt = '0;
            end
          end
        end
        default: begin
          // idle and the unused code: any pulse arms the block
          phase_nxt      = PH_START;
          bit_count_nxt  = '0;
          byte_shift_nxt = '0;
          byte_idx_nxt   = '0;
          run_sum_nxt    = '0;
          code_ok_nxt    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      byte_shift_r <= '0;
      byte_idx_r   <= '0;
      run_sum_r    <= '0;
      code_ok_r    <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      byte_shift_r <= byte_shift_nxt;
      byte_idx_r   <= byte_idx_nxt;
      run_sum_r    <= run_sum_nxt;
      code_ok_r    <= code_ok_nxt;
    end
  end

endmodule

/* hw/rtl/ir_pulse_width_frame_decoder_unit.sv */
// IR pulse-width frame decoder, top level. Depends on irpwd_pkg,
// irpwd_cfg_regs and irpwd_frame_fsm.
// A pulse that completes a byte has its word on the outputs once it has passed
// the input register, then the result register.
// Throughput: one pulse per cycle; a result word left waiting holds the input.
// Reset (synchronous, rst_n low): idle, frame counters cleared, config at
// defaults, both registers empty.
module ir_pulse_width_frame_decoder_unit #(
  parameter int FRAME_BYTES = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_pulse_width,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte_value,
  output logic [3:0]                    out_byte_index,
  output logic                          out_last_byte,
  output logic [1:0]                    out_frame_status,
  input  logic                          cfg_we,
  input  logic [irpwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import irpwd_pkg::*;

  cfg_t       cfg;
  logic       in_vld_r;
  logic [7:0] width_r;
  logic       out_vld_r;
  result_t    out_r;
  logic       out_free;
  logic       step;
  logic       res_vld;
  result_t    res;

  irpwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the FSM steps only when the result register can take a word
  assign out_free = !out_vld_r || out_ready;
  assign step     = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      width_r <= in_pulse_width;
    end
  end

  irpwd_frame_fsm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .pulse_width (width_r),
    .cfg         (cfg),
    .res_vld     (res_vld),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_value   = out_r.byte_value;
  assign out_byte_index   = out_r.byte_index;
  assign out_last_byte    = out_r.last_byte;
  assign out_frame_status = out_r.frame_status;

endmodule

/* dv/ir_pulse_width_frame_decoder_unit_tb.sv */
// Self-checking testbench for ir_pulse_width_frame_decoder_unit.
// Holds its own frame decoder model, drives pulse widths and config writes,
// and checks every output word in order. Depends on irpwd_pkg and the RTL.
module ir_pulse_width_frame_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irpwd_pkg::*;

  localparam int FRAME_LEN      = 14;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_GAP        = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int STREAM_PULSES  = 240;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CODE,
    FRAME_BAD_SUM,
    FRAME_BAD_BOTH
  } frame_kind_t;

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_pulse_width   = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [7:0]           out_byte_value;
  logic [3:0]           out_byte_index;
  logic                 out_last_byte;
  logic [1:0]           out_frame_status;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [7:0]           cfg_data         = '0;

  // Frame decoder model state
  cfg_t       model_cfg;
  phase_t     dec_phase;
  logic [2:0] bit_cnt;
  logic [7:0] shift_acc;
  logic [3:0] byte_idx;
  logic [7:0] sum_acc;
  logic       code_ok;

  result_t expected_bytes[$];
  int      mismatches     = 0;
  int      pulses_sent    = 0;
  int      idle_cycles    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles    = 0;

  ir_pulse_width_frame_decoder_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pulse_width  (in_pulse_width),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_value  (out_byte_value),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte),
    .out_frame_status(out_frame_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------

  function automatic logic width_in(input logic [7:0] w, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (w >= lo) && (w <= hi);
  endfunction

  function automatic cfg_t make_cfg(input logic [7:0] smin, input logic [7:0] smax,
                                    input logic [7:0] zmin, input logic [7:0] zmax,
                                    input logic [7:0] omin, input logic [7:0] omax,
                                    input logic [7:0] code);
    cfg_t c;
    c.start_min = smin;
    c.start_max = smax;
    c.zero_min  = zmin;
    c.zero_max  = zmax;
    c.one_min   = omin;
    c.one_max   = omax;
    c.id_code   = code;
    return c;
  endfunction

  function automatic void clear_frame_state();
    bit_cnt   = '0;
    shift_acc = '0;
    byte_idx  = '0;
    sum_acc   = '0;
    code_ok   = 1'b0;
  endfunction

  // Advance the model by one pulse; queue the byte word it completes, if any
  task automatic decode_pulse(input logic [7:0] w);
    logic       bit_val;
    logic [7:0] b;
    logic [3:0] idx;
    logic       last;
    status_t    st;
    result_t    r;
    case (dec_phase)
      PH_START: begin
        clear_frame_state();
        dec_phase = width_in(w, model_cfg.start_min, model_cfg.start_max) ? PH_BITS : PH_IDLE;
      end
      PH_BITS: begin
        // zero window wins where the windows overlap
        if (width_in(w, model_cfg.zero_min, model_cfg.zero_max)) begin
          bit_val = 1'b0;
        end else if (width_in(w, model_cfg.one_min, model_cfg.one_max)) begin
          bit_val = 1'b1;
        end else begin
          dec_phase = PH_IDLE;
          clear_frame_state();
          return;
        end
        shift_acc = shift_acc | (8'(bit_val) << bit_cnt);
        if (bit_cnt < 3'd7) begin
          bit_cnt = bit_cnt + 3'd1;
        end else begin
          b    = shift_acc;
          idx  = byte_idx;
          last = (int'(idx) + 1 >= FRAME_LEN);
          if (idx == 4'd0) code_ok = (b == model_cfg.id_code);
          st = ST_PROGRESS;
          // user code is judged before the checksum
          if (last) st = !code_ok ? ST_BAD_CODE : ((sum_acc == b) ? ST_GOOD : ST_BAD_SUM);
          r.byte_value   = b;
          r.byte_index   = idx;
          r.last_byte    = last;
          r.frame_status = st;
          expected_bytes.push_back(r);
          if (last) begin
            dec_phase = PH_IDLE;
            clear_frame_state();
          end else begin
            sum_acc   = sum_acc + b;
            byte_idx  = idx + 4'd1;
            bit_cnt   = '0;
            shift_acc = '0;
          end
        end
      end
      default: begin
        // idle: any pulse arms the decoder
        clear_frame_state();
        dec_phase = PH_START;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  // Compare each output word with the oldest expected byte
  always @(posedge clk) begin : check_words
    result_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected word byte=%02h idx=%0d last=%0b st=%0d",
                                out_byte_value, out_byte_index, out_last_byte,
                                out_frame_status));
      end else begin
        exp_w = expected_bytes.pop_front();
        if (out_byte_value !== exp_w.byte_value || out_byte_index !== exp_w.byte_index ||
            out_last_byte !== exp_w.last_byte || out_frame_status !== exp_w.frame_status) begin
          note_mismatch($sformatf(
            "exp byte=%02h idx=%0d last=%0b st=%0d got byte=%02h idx=%0d last=%0b st=%0d",
            exp_w.byte_value, exp_w.byte_index, exp_w.last_byte, exp_w.frame_status,
            out_byte_value, out_byte_index, out_last_byte, out_frame_status));
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offer one pulse word, wait for acceptance, update the model
  task automatic send_pulse(input logic [7:0] w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pulse_width <= w;
    do @(posedge clk); while (!in_ready);
    decode_pulse(w);
    pulses_sent++;
  endtask

  task automatic play(input logic [7:0] seq[$]);
    foreach (seq[i]) send_pulse(seq[i]);
  endtask

  // Drop valid, let every expected word arrive and the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_START_MIN: model_cfg.start_min = val;
      CFG_START_MAX: model_cfg.start_max = val;
      CFG_ZERO_MIN:  model_cfg.zero_min  = val;
      CFG_ZERO_MAX:  model_cfg.zero_max  = val;
      CFG_ONE_MIN:   model_cfg.one_min   = val;
      CFG_ONE_MAX:   model_cfg.one_max   = val;
      CFG_ID_CODE:   model_cfg.id_code   = val;
      default: ;
    endcase
  endtask

  // Program all registers while idle; optionally poke the unused index too
  task automatic load_cfg(input cfg_t c, input bit poke_unused);
    wait_idle();
    write_reg(CFG_START_MIN, c.start_min);
    write_reg(CFG_START_MAX, c.start_max);
    write_reg(CFG_ZERO_MIN,  c.zero_min);
    write_reg(CFG_ZERO_MAX,  c.zero_max);
    write_reg(CFG_ONE_MIN,   c.one_min);
    write_reg(CFG_ONE_MAX,   c.one_max);
    write_reg(CFG_ID_CODE,   c.id_code);
    if (poke_unused) write_reg(CFG_UNUSED_IDX, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
    if (lo <= hi) return 8'($urandom_range(hi, lo));
    return 8'($urandom_range(255, 0));
  endfunction

  // Width for one data bit; a 1 avoids the zero window where it can
  function automatic logic [7:0] bit_pulse(input logic b);
    logic [7:0] w;
    if (!b) return pick_in(model_cfg.zero_min, model_cfg.zero_max);
    w = pick_in(model_cfg.one_min, model_cfg.one_max);
    for (int t = 0; t < 8 && width_in(w, model_cfg.zero_min, model_cfg.zero_max); t++)
      w = pick_in(model_cfg.one_min, model_cfg.one_max);
    return w;
  endfunction

  // Width outside both bit windows
  function automatic logic [7:0] abort_pulse();
    logic [7:0] w;
    for (int t = 0; t < 16; t++) begin
      w = 8'($urandom);
      if (!width_in(w, model_cfg.zero_min, model_cfg.zero_max) &&
          !width_in(w, model_cfg.one_min, model_cfg.one_max)) return w;
    end
    for (int v = 0; v < 256; v++) begin
      if (!width_in(8'(v), model_cfg.zero_min, model_cfg.zero_max) &&
          !width_in(8'(v), model_cfg.one_min, model_cfg.one_max)) return 8'(v);
    end
    return 8'hFF;
  endfunction

  // Non-overlapping bit windows with an abort band above the zero window
  function automatic cfg_t random_cfg();
    int omin, omax, zmin, zmax, smin, smax;
    omin = $urandom_range(60, 0);
    omax = omin + $urandom_range(30, 0);
    zmin = omax + 1 + $urandom_range(20, 0);
    zmax = zmin + $urandom_range(30, 0);
    smin = $urandom_range(200, 0);
    smax = smin + $urandom_range(55, 0);
    return make_cfg(8'(smin), 8'(smax), 8'(zmin), 8'(zmax), 8'(omin), 8'(omax),
                    8'($urandom));
  endfunction

  // Bring the decoder to the bit phase from wherever it is
  task automatic enter_frame();
    if (dec_phase == PH_BITS) send_pulse(abort_pulse());
    if (dec_phase != PH_START) send_pulse(8'($urandom));
    send_pulse(pick_in(model_cfg.start_min, model_cfg.start_max));
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fb[FRAME_LEN];
    logic [7:0] sum;
    sum   = '0;
    fb[0] = (kind == FRAME_GOOD || kind == FRAME_BAD_SUM) ?
            model_cfg.id_code : model_cfg.id_code ^ 8'($urandom_range(255, 1));
    for (int i = 1; i < FRAME_LEN - 1; i++) fb[i] = 8'($urandom);
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + fb[i];
    fb[FRAME_LEN-1] = (kind == FRAME_GOOD || kind == FRAME_BAD_CODE) ?
                      sum : sum ^ 8'($urandom_range(255, 1));
    enter_frame();
    for (int i = 0; i < FRAME_LEN; i++) begin
      for (int k = 0; k < 8; k++) send_pulse(bit_pulse(fb[i][k]));
    end
  endtask

  // Failed starts, noise bursts and frames cut short
  task automatic send_broken();
    case ($urandom_range(2))
      0: begin
        send_pulse(8'($urandom));
        send_pulse(8'($urandom));
      end
      1: repeat ($urandom_range(6, 1)) send_pulse(8'($urandom));
      default: begin
        enter_frame();
        repeat ($urandom_range(60, 1)) send_pulse(bit_pulse(1'($urandom)));
        send_pulse(abort_pulse());
      end
    endcase
  endtask

  task automatic run_frames(input int budget);
    int first;
    int r;
    first = pulses_sent;
    while (pulses_sent - first < budget) begin
      r = $urandom_range(99);
      if (r < 45)      send_frame(FRAME_GOOD);
      else if (r < 55) send_frame(FRAME_BAD_CODE);
      else if (r < 65) send_frame(FRAME_BAD_SUM);
      else if (r < 75) send_frame(FRAME_BAD_BOTH);
      else             send_broken();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Default windows: failed starts at both edges, bit window edges, abort, one byte
  task automatic test_directed();
    logic [7:0] seq[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    seq = '{8'd0, 8'd139, 8'd255, 8'd176, 8'h5A, 8'd140, 8'd39, 8'd53, 8'd16, 8'd30,
            8'd54, 8'd0, 8'd175, 8'd16, 8'd53, 8'd30, 8'd39, 8'd16, 8'd16, 8'd39,
            8'd30, 8'd255};
    play(seq);
  endtask

  // Overlapping windows, empty windows and the narrowest extreme setting
  task automatic test_window_corners();
    logic [7:0] seq[$];
    load_cfg(make_cfg(8'd140, 8'd175, 8'd20, 8'd40, 8'd30, 8'd50, 8'd10), 1'b0);
    seq = '{8'd7, 8'd150, 8'd35, 8'd45, 8'd40, 8'd50, 8'd100};
    play(seq);
    // bit windows empty: any bit width aborts
    load_cfg(make_cfg(8'd140, 8'd175, 8'd60, 8'd50, 8'd30, 8'd20, 8'd10), 1'b0);
    seq = '{8'd1, 8'd160, 8'd55};
    play(seq);
    // start window empty
    load_cfg(make_cfg(8'd200, 8'd100, 8'd39, 8'd53, 8'd16, 8'd30, 8'd10), 1'b0);
    seq = '{8'd1, 8'd150};
    play(seq);
    load_cfg(make_cfg(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 1'b0);
    seq = '{8'd3, 8'd255, 8'd255, 8'd0, 8'd128};
    play(seq);
  endtask

  // One frame of each status under the reset windows, light idling
  task automatic test_frame_status();
    load_cfg(make_cfg(RST_START_MIN, RST_START_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                      RST_ONE_MIN, RST_ONE_MAX, RST_ID_CODE), 1'b0);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    send_frame(FRAME_GOOD);
    send_frame(FRAME_BAD_CODE);
    send_frame(FRAME_BAD_SUM);
    send_frame(FRAME_BAD_BOTH);
  endtask

  task automatic test_clean_stream();
    load_cfg(random_cfg(), 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_frames(STREAM_PULSES);
  endtask

  // Widest windows, with a write to the unused index that must change nothing
  task automatic test_sender_gaps();
    load_cfg(make_cfg(8'd0, 8'd255, 8'd100, 8'd254, 8'd0, 8'd99, 8'hFF), 1'b1);
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    run_frames(STREAM_PULSES);
  endtask

  task automatic test_receiver_stalls();
    load_cfg(make_cfg(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    run_frames(STREAM_PULSES);
  endtask

  task automatic test_mixed_idling();
    load_cfg(random_cfg(), 1'b1);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    run_frames(STREAM_PULSES);
  endtask

  // Long receiver hold-off while pulses keep coming: the pipe fills and stalls
  task automatic test_backpressure();
    load_cfg(random_cfg(), 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = HOLD_CYCLES;
    send_frame(FRAME_GOOD);
    send_frame(FRAME_BAD_SUM);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    model_cfg = make_cfg(RST_START_MIN, RST_START_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                         RST_ONE_MIN, RST_ONE_MAX, RST_ID_CODE);
    dec_phase = PH_IDLE;
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_window_corners();
    test_frame_status();
    test_clean_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();

    wait_idle();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
